// File: rtl/core/bsbt_pkg.sv
package bsbt_pkg;

   // table geometry
   localparam int NUM_SLOTS   = 64;
   localparam int SLOT_BYTES  = 64;
   localparam int MAP_BITS    = 64;
   localparam int STORE_DEPTH = NUM_SLOTS * SLOT_BYTES;
   localparam int STORE_AW    = 12;

   // slots that exist in the occupancy map
   localparam logic [MAP_BITS-1:0] SLOT_MASK =
      (NUM_SLOTS >= MAP_BITS) ? '1 : ((64'd1 << NUM_SLOTS) - 64'd1);

   typedef enum logic [2:0] {
      CMD_ALLOC      = 3'd0,
      CMD_FREE       = 3'd1,
      CMD_WRITE_OPEN = 3'd2,
      CMD_WRITE_DATA = 3'd3,
      CMD_READ       = 3'd4,
      CMD_QUERY      = 3'd5,
      CMD_CLEAR_ALL  = 3'd6,
      CMD_UNMARK_ALL = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      STS_OK       = 3'd0,
      STS_BAD_SLOT = 3'd1,
      STS_SIZE     = 3'd2,
      STS_FULL     = 3'd3,
      STS_BUSY     = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_STREAM
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic capture;
      logic exec;
      logic stream;
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic stream_go;
      logic stream_last;
   } dp_stat_type;

   // lowest clear bit of the map: {found, group, bit}, two levels of eight
   function automatic logic [6:0] first_free(input logic [MAP_BITS-1:0] occ);
      logic [7:0] grp_free;
      logic [7:0] row;
      logic [2:0] grp;
      logic [2:0] pos;
      logic       found;
      for (int i = 0; i < 8; i++) begin
         grp_free[i] = ~&occ[i*8 +: 8];
      end
      found = 1'b0;
      grp   = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (grp_free[i]) begin
            found = 1'b1;
            grp   = 3'(i);
         end
      end
      row = occ[grp*8 +: 8];
      pos = 3'd0;
      for (int i = 7; i >= 0; i--) begin
         if (!row[i]) begin
            pos = 3'(i);
         end
      end
      return {found, grp, pos};
   endfunction

endpackage

// File: rtl/core/bsbt_ctrl.sv
module bsbt_ctrl import bsbt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  dp_stat_type stat,
   output ctl_cmd_type ctl,
   output logic        busy
);

   state_type state_ff;
   state_type state_in;

   // hold state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // sequence: take a command, execute it, stream bytes for a read
   always_comb begin
      state_in    = state_ff;
      ctl.capture = 1'b0;
      ctl.exec    = 1'b0;
      ctl.stream  = 1'b0;
      busy        = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            busy = 1'b0;
            if (start) begin
               ctl.capture = 1'b1;
               state_in    = S_EXEC;
            end
         end
         S_EXEC: begin
            ctl.exec = 1'b1;
            state_in = stat.stream_go ? S_STREAM : S_IDLE;
         end
         S_STREAM: begin
            ctl.stream = 1'b1;
            if (stat.stream_last) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// File: rtl/core/bsbt_dpath.sv
module bsbt_dpath import bsbt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  ctl_cmd_type ctl,
   output dp_stat_type stat,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_slot,
   input  logic [15:0] req_length,
   input  logic [15:0] req_capacity,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_slot_out,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_last,
   output logic [6:0]  rsp_blob_length,
   output logic        rsp_is_active,
   output logic [6:0]  rsp_active_count
);

   // captured command
   cmd_type     cmd_ff;
   logic [7:0]  slot_ff;
   logic [15:0] length_ff;
   logic [15:0] capacity_ff;
   logic [7:0]  data_ff;

   // table state
   logic [MAP_BITS-1:0] map_ff, map_in;
   logic [6:0]          cnt_ff, cnt_in;
   logic                open_ff, open_in;
   logic [5:0]          pslot_ff, pslot_in;
   logic [6:0]          plen_ff, plen_in;
   logic [6:0]          pidx_ff, pidx_in;
   logic [MAP_BITS-1:0] len_vld_ff;

   // length table and byte store
   logic [6:0] len_mem [MAP_BITS];
   logic [6:0] len_rd_ff;
   logic       len_we;
   logic [5:0] len_wa;
   logic [6:0] len_wd;
   logic       clr_vld;

   logic [7:0]          store_mem [STORE_DEPTH];
   logic [7:0]          store_rd_ff;
   logic                st_we;
   logic [STORE_AW-1:0] st_waddr;
   logic [STORE_AW-1:0] st_raddr;
   logic [5:0]          rd_ptr;

   // read streaming
   logic [6:0] n_ff, n_in;
   logic [6:0] idx_ff, idx_in;

   // response
   logic       rsp_valid_ff, rsp_valid_in;
   status_type sts_ff, sts_in;
   logic [5:0] slot_out_ff, slot_out_in;
   logic [7:0] byte_ff, byte_in;
   logic       bvld_ff, bvld_in;
   logic       last_ff, last_in;
   logic [6:0] blen_ff, blen_in;
   logic       act_ff, act_in;

   logic       in_range;
   logic       slot_on;
   logic [6:0] len_cur;
   logic [6:0] ff_res;
   logic [6:0] pidx_nx;

   // capture the command at the accepting transfer
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         cmd_ff      <= cmd_type'(req_command);
         slot_ff     <= req_slot;
         length_ff   <= req_length;
         capacity_ff <= req_capacity;
         data_ff     <= req_data_byte;
      end
   end

   // length table: read at capture, one write port
   always_ff @(posedge clock) begin
      if (ctl.capture) begin
         len_rd_ff <= len_mem[req_slot[5:0]];
      end
      if (len_we) begin
         len_mem[len_wa] <= len_wd;
      end
   end

   // byte store: one write and one registered read a cycle
   assign pidx_nx  = 7'(pidx_ff + 7'd1);
   assign rd_ptr   = ctl.stream ? 6'(idx_ff + 7'd1) : 6'd0;
   assign st_waddr = 12'(12'(pslot_ff) * 12'(SLOT_BYTES) + 12'(pidx_ff[5:0]));
   assign st_raddr = 12'(12'(slot_ff[5:0]) * 12'(SLOT_BYTES) + 12'(rd_ptr));

   always_ff @(posedge clock) begin
      if (st_we) begin
         store_mem[st_waddr] <= data_ff;
      end
      store_rd_ff <= store_mem[st_raddr];
   end

   assign in_range = {1'b0, slot_ff} < 9'(NUM_SLOTS);
   assign slot_on  = in_range && map_ff[slot_ff[5:0]];
   assign len_cur  = len_vld_ff[slot_ff[5:0]] ? len_rd_ff : 7'd0;
   assign ff_res   = first_free(map_ff | ~SLOT_MASK);

   // execute one command or emit one streamed byte
   always_comb begin
      map_in       = map_ff;
      cnt_in       = cnt_ff;
      open_in      = open_ff;
      pslot_in     = pslot_ff;
      plen_in      = plen_ff;
      pidx_in      = pidx_ff;
      len_we       = 1'b0;
      len_wa       = slot_ff[5:0];
      len_wd       = 7'd0;
      clr_vld      = 1'b0;
      st_we        = 1'b0;
      n_in         = n_ff;
      idx_in       = idx_ff;
      stat         = '0;
      rsp_valid_in = 1'b0;
      sts_in       = STS_OK;
      slot_out_in  = 6'd0;
      byte_in      = 8'd0;
      bvld_in      = 1'b0;
      last_in      = 1'b1;
      blen_in      = 7'd0;
      act_in       = 1'b0;
      if (ctl.exec) begin
         rsp_valid_in = 1'b1;
         n_in         = len_cur;
         idx_in       = 7'd0;
         if (open_ff && cmd_ff != CMD_WRITE_DATA) begin
            sts_in = STS_BUSY;
         end else begin
            unique case (cmd_ff)
               CMD_ALLOC: begin
                  if (ff_res[6]) begin
                     map_in[ff_res[5:0]] = 1'b1;
                     cnt_in      = 7'(cnt_ff + 7'd1);
                     slot_out_in = ff_res[5:0];
                  end else begin
                     sts_in = STS_FULL;
                  end
               end
               CMD_FREE: begin
                  if (!slot_on) begin
                     sts_in = STS_BAD_SLOT;
                  end else begin
                     map_in[slot_ff[5:0]] = 1'b0;
                     cnt_in = 7'(cnt_ff - 7'd1);
                     len_we = 1'b1;
                  end
               end
               CMD_WRITE_OPEN: begin
                  if (!slot_on) begin
                     sts_in = STS_BAD_SLOT;
                  end else if (length_ff > 16'(SLOT_BYTES)) begin
                     sts_in = STS_SIZE;
                  end else if (length_ff == 16'd0) begin
                     len_we = 1'b1;
                  end else begin
                     open_in  = 1'b1;
                     pslot_in = slot_ff[5:0];
                     plen_in  = length_ff[6:0];
                     pidx_in  = 7'd0;
                  end
               end
               CMD_WRITE_DATA: begin
                  if (!open_ff) begin
                     sts_in = STS_BUSY;
                  end else begin
                     // store the byte; commit the length on the last one
                     st_we   = 1'b1;
                     pidx_in = pidx_nx;
                     if (pidx_nx >= plen_ff) begin
                        len_we  = 1'b1;
                        len_wa  = pslot_ff;
                        len_wd  = plen_ff;
                        open_in = 1'b0;
                     end
                  end
               end
               CMD_READ: begin
                  if (!slot_on) begin
                     sts_in = STS_BAD_SLOT;
                  end else if ({9'd0, len_cur} > capacity_ff) begin
                     sts_in = STS_SIZE;
                  end else if (len_cur != 7'd0) begin
                     // bytes follow from the stream
                     stat.stream_go = 1'b1;
                     rsp_valid_in   = 1'b0;
                  end
               end
               CMD_QUERY: begin
                  if (!in_range) begin
                     sts_in = STS_BAD_SLOT;
                  end else if (slot_on) begin
                     blen_in = len_cur;
                     act_in  = 1'b1;
                  end
               end
               CMD_CLEAR_ALL: begin
                  map_in   = '0;
                  cnt_in   = 7'd0;
                  clr_vld  = 1'b1;
                  open_in  = 1'b0;
                  pslot_in = 6'd0;
                  plen_in  = 7'd0;
                  pidx_in  = 7'd0;
               end
               CMD_UNMARK_ALL: begin
                  map_in = '0;
                  cnt_in = 7'd0;
               end
               default: begin
                  sts_in = STS_OK;
               end
            endcase
         end
      end else if (ctl.stream) begin
         rsp_valid_in     = 1'b1;
         byte_in          = store_rd_ff;
         bvld_in          = 1'b1;
         last_in          = (7'(idx_ff + 7'd1) == n_ff);
         blen_in          = n_ff;
         idx_in           = 7'(idx_ff + 7'd1);
         stat.stream_last = last_in;
      end
   end

   // advance control state
   always_ff @(posedge clock) begin
      if (reset) begin
         map_ff       <= '0;
         cnt_ff       <= 7'd0;
         open_ff      <= 1'b0;
         pslot_ff     <= 6'd0;
         plen_ff      <= 7'd0;
         pidx_ff      <= 7'd0;
         len_vld_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         map_ff       <= map_in;
         cnt_ff       <= cnt_in;
         open_ff      <= open_in;
         pslot_ff     <= pslot_in;
         plen_ff      <= plen_in;
         pidx_ff      <= pidx_in;
         rsp_valid_ff <= rsp_valid_in;
         if (clr_vld) begin
            len_vld_ff <= '0;
         end else if (len_we) begin
            len_vld_ff[len_wa] <= 1'b1;
         end
      end
   end

   // hold stream position and response payload
   always_ff @(posedge clock) begin
      n_ff   <= n_in;
      idx_ff <= idx_in;
      if (rsp_valid_in) begin
         sts_ff      <= sts_in;
         slot_out_ff <= slot_out_in;
         byte_ff     <= byte_in;
         bvld_ff     <= bvld_in;
         last_ff     <= last_in;
         blen_ff     <= blen_in;
         act_ff      <= act_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = sts_ff;
   assign rsp_slot_out     = slot_out_ff;
   assign rsp_out_byte     = byte_ff;
   assign rsp_byte_valid   = bvld_ff;
   assign rsp_last         = last_ff;
   assign rsp_blob_length  = blen_ff;
   assign rsp_is_active    = act_ff;
   assign rsp_active_count = cnt_ff;

endmodule

// File: rtl/core/bitmap_slot_blob_table.sv
// Slot table of 64 slots of 64 bytes with an occupancy bitmap. A command is
// taken when start is high and busy is low; every command but a non-empty
// read answers with one result, strobed by rsp_valid for a single cycle
// from a register loaded in the execute state, and busy is high for the one
// cycle between. A read of n bytes keeps busy high through the execute state
// and the stream, and delivers one byte per cycle, the first once the byte
// store's registered read has returned it, with rsp_last on the final byte.
// The length table and the byte store both have registered reads. Results
// cannot be held off: sample them whenever rsp_valid is high. While a blob
// write is open, any command other than a data byte answers busy status and
// changes nothing.
module bitmap_slot_blob_table import bsbt_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_command,
   input  logic [7:0]  req_slot,
   input  logic [15:0] req_length,
   input  logic [15:0] req_capacity,
   input  logic [7:0]  req_data_byte,
   output logic        rsp_valid,
   output logic [2:0]  rsp_status,
   output logic [5:0]  rsp_slot_out,
   output logic [7:0]  rsp_out_byte,
   output logic        rsp_byte_valid,
   output logic        rsp_last,
   output logic [6:0]  rsp_blob_length,
   output logic        rsp_is_active,
   output logic [6:0]  rsp_active_count
);

   ctl_cmd_type ctl;
   dp_stat_type stat;

   bsbt_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .stat  (stat),
      .ctl   (ctl),
      .busy  (busy)
   );

   bsbt_dpath u_dpath (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .stat             (stat),
      .req_command      (req_command),
      .req_slot         (req_slot),
      .req_length       (req_length),
      .req_capacity     (req_capacity),
      .req_data_byte    (req_data_byte),
      .rsp_valid        (rsp_valid),
      .rsp_status       (rsp_status),
      .rsp_slot_out     (rsp_slot_out),
      .rsp_out_byte     (rsp_out_byte),
      .rsp_byte_valid   (rsp_byte_valid),
      .rsp_last         (rsp_last),
      .rsp_blob_length  (rsp_blob_length),
      .rsp_is_active    (rsp_is_active),
      .rsp_active_count (rsp_active_count)
   );

   // a streamed byte always belongs to a successful read
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_byte_valid |-> rsp_status == STS_OK)
      else $error("byte result with non-ok status");

   // a read stream that is not finished keeps the block busy
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> busy)
      else $error("stream ended without last");

   // an accepted command occupies the block for the next cycle
   assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted command not executed");

   // the active count never exceeds the slot count
   assert property (@(posedge clock) disable iff (reset)
      rsp_active_count <= 7'(NUM_SLOTS))
      else $error("active count out of range");

endmodule
